>>> hw/rtl/bms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_pkg: shared constants, types and level table
// fixed-point gains, millivolt limits and the sigmoid threshold table
// ----------------------------------------------------------------------------
package bms_pkg;

  localparam int AdcW     = 12;
  localparam int MvW      = 16;
  localparam int LevelW   = 7;
  localparam int ThrW     = 10;
  localparam int AvgW     = AdcW;
  localparam int AdcMax   = 4095;

  localparam int MvGain      = 7086;
  localparam int MvGainShift = 10;
  localparam int MvMulW      = AvgW + 13;
  localparam int MvOffset    = 337;
  localparam int MvEmpty     = 3200;
  localparam int MvFull      = 4200;
  localparam int LevelMax    = 100;
  localparam int CurveTop    = 105;
  localparam int SlopeMilli  = 1724;

  localparam int LowThrReset       = 3300;
  localparam int SamplesPerReading = 5;

  typedef logic [MvW-1:0]    mv_t;
  typedef logic [LevelW-1:0] level_t;
  typedef logic [ThrW-1:0]   thr_t;
  typedef logic [LevelMax:1][ThrW-1:0] thr_tbl_t;

  // smallest offset above the empty voltage at which each level is reached,
  // found exactly by bisection on (1724*d)^11 * (105-lv)^2 >= lv^2 * 10^66;
  // clipped to the table width
  function automatic thr_tbl_t build_level_thr();
    thr_tbl_t     tbl;
    logic [287:0] lhs;
    logic [287:0] rhs;
    int           lo;
    int           hi;
    int           mid;
    tbl = '0;
    for (int lv = 1; lv <= LevelMax; lv++) begin
      rhs = 288'(lv * lv);
      for (int i = 0; i < 66; i++) begin
        rhs = rhs * 288'(10);
      end
      lo = 1;
      hi = (1 << ThrW) - 1;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        lhs = 288'((CurveTop - lv) * (CurveTop - lv));
        for (int i = 0; i < 11; i++) begin
          lhs = lhs * 288'(SlopeMilli * mid);
        end
        if (lhs >= rhs) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      tbl[lv] = ThrW'(lo);
    end
    return tbl;
  endfunction

  localparam thr_tbl_t LevelThr = build_level_thr();

endpackage

>>> hw/rtl/bms_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_accum: sample accumulator
// sums adc samples and hands each completed group sum downstream
// ----------------------------------------------------------------------------
module bms_accum import bms_pkg::*; #(
  parameter int SAMPLES_PER_READING = SamplesPerReading,
  parameter int SumW = $clog2(AdcMax * SAMPLES_PER_READING + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [AdcW-1:0]   adc_sample_i,
  output logic              grp_valid_o,
  input  logic              grp_ready_i,
  output logic [SumW-1:0]   grp_sum_o
);

  localparam int CntW = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;

  logic [SumW-1:0] sum_q, sum_d, sum_next;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            grp_v_q, grp_v_d;
  logic [SumW-1:0] grp_sum_q, grp_sum_d;
  logic            take, last;

  assign in_ready_o = !grp_v_q || grp_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign last       = (cnt_q == CntW'(SAMPLES_PER_READING - 1));
  assign sum_next   = sum_q + SumW'(adc_sample_i);

  always_comb begin
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    grp_sum_d = grp_sum_q;
    grp_v_d   = grp_v_q && !grp_ready_i;
    if (take) begin
      if (last) begin
        sum_d     = '0;
        cnt_d     = '0;
        grp_sum_d = sum_next;
        grp_v_d   = 1'b1;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      cnt_q   <= '0;
      grp_v_q <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      grp_v_q <= grp_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_sum_q <= grp_sum_d;
  end

  assign grp_valid_o = grp_v_q;
  assign grp_sum_o   = grp_sum_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(SAMPLES_PER_READING - 1))
    else $error("sample count past group size");

  a_grp_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && last |=> grp_v_q && sum_q == '0)
    else $error("group completion did not load group register");

endmodule

>>> hw/rtl/bms_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_convert: average and millivolt conversion
// reciprocal divide with one-step correction, then gain and offset
// ----------------------------------------------------------------------------
module bms_convert import bms_pkg::*; #(
  parameter int SAMPLES_PER_READING = SamplesPerReading,
  parameter int SumW = $clog2(AdcMax * SAMPLES_PER_READING + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            grp_valid_i,
  output logic            grp_ready_o,
  input  logic [SumW-1:0] grp_sum_i,
  output logic            mv_valid_o,
  input  logic            mv_ready_i,
  output mv_t             mv_o
);

  localparam int                ProdW    = 2 * SumW + 1;
  localparam longint unsigned   RecipVal = (64'd1 << SumW) / SAMPLES_PER_READING;
  localparam logic [SumW:0]     Recip    = (SumW + 1)'(RecipVal);

  // stage a: estimated quotient, at most one below the true one
  logic            a_v_q, a_rdy;
  logic [SumW-1:0] a_sum_q;
  logic [AvgW-1:0] a_q0_q, a_q0_d;
  logic [ProdW-1:0] a_prod;

  // stage b: corrected average
  logic            b_v_q, b_rdy;
  logic [AvgW-1:0] b_avg_q, b_avg_d;
  logic [SumW-1:0] b_rem;

  // stage c: millivolts
  logic            c_v_q, c_rdy;
  mv_t             c_mv_q, c_mv_d;
  logic [MvMulW-1:0] c_prod;

  assign c_rdy = !c_v_q || mv_ready_i;
  assign b_rdy = !b_v_q || c_rdy;
  assign a_rdy = !a_v_q || b_rdy;
  assign grp_ready_o = a_rdy;

  assign a_prod = ProdW'(grp_sum_i) * ProdW'(Recip);
  assign a_q0_d = a_prod[SumW +: AvgW];

  assign b_rem   = a_sum_q - SumW'(a_q0_q * SAMPLES_PER_READING);
  assign b_avg_d = a_q0_q + AvgW'(b_rem >= SumW'(SAMPLES_PER_READING));

  // largest average gives well under 16 bits, so no saturation is needed
  assign c_prod = MvMulW'(b_avg_q) * MvMulW'(MvGain);
  assign c_mv_d = MvW'(c_prod >> MvGainShift) + MvW'(MvOffset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v_q <= grp_valid_i;
      end
      if (b_rdy) begin
        b_v_q <= a_v_q;
      end
      if (c_rdy) begin
        c_v_q <= b_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      a_sum_q <= grp_sum_i;
      a_q0_q  <= a_q0_d;
    end
    if (b_rdy) begin
      b_avg_q <= b_avg_d;
    end
    if (c_rdy) begin
      c_mv_q <= c_mv_d;
    end
  end

  assign mv_valid_o = c_v_q;
  assign mv_o       = c_mv_q;

endmodule

>>> hw/rtl/bms_level.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_level: state of charge and low flag
// compares the offset against the level table and holds the result register
// ----------------------------------------------------------------------------
module bms_level import bms_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   mv_valid_i,
  output logic   mv_ready_o,
  input  mv_t    mv_i,
  input  mv_t    low_thr_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output mv_t    battery_mv_o,
  output level_t level_percent_o,
  output logic   battery_low_o
);

  logic                 out_v_q;
  mv_t                  mv_q;
  level_t               level_q, level_d;
  logic                 low_q, low_d;
  thr_t                 offs;
  logic [LevelMax+1:1]  hit;
  level_t               curve;

  assign mv_ready_o = !out_v_q || out_ready_i;
  assign offs       = ThrW'(mv_i - MvW'(MvEmpty));

  // table is ascending, so the hits form a thermometer; encode its top
  always_comb begin
    hit   = '0;
    curve = '0;
    for (int lv = 1; lv <= LevelMax; lv++) begin
      hit[lv] = (offs >= LevelThr[lv]);
    end
    for (int lv = 1; lv <= LevelMax; lv++) begin
      if (hit[lv] && !hit[lv+1]) begin
        curve = curve | LevelW'(lv);
      end
    end
  end

  always_comb begin
    if (mv_i >= MvW'(MvFull)) begin
      level_d = LevelW'(LevelMax);
    end else if (mv_i <= MvW'(MvEmpty)) begin
      level_d = '0;
    end else begin
      level_d = curve;
    end
    low_d = (mv_i < low_thr_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (mv_ready_o) begin
      out_v_q <= mv_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv_ready_o) begin
      mv_q    <= mv_i;
      level_q <= level_d;
      low_q   <= low_d;
    end
  end

  assign out_valid_o     = out_v_q;
  assign battery_mv_o    = mv_q;
  assign level_percent_o = level_q;
  assign battery_low_o   = low_q;

endmodule

>>> hw/rtl/battery_monitor_soc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_monitor_soc: battery voltage and state-of-charge monitor
// averages groups of adc samples, converts to millivolts, reports level
// ----------------------------------------------------------------------------
// path: the transfer of the sample that completes a group loads the group
//   register, then the result passes the quotient, correction, millivolt and
//   output registers; a stall at any stage holds it there
// throughput: one sample per cycle while the group register is free or being
//   taken, one result per SAMPLES_PER_READING samples; the stage valid/ready chain
//   lets a waiting result sit without stalling input until five readings are held
// reset: clears sum, count and every stage valid; threshold returns to 3300 mV
// ----------------------------------------------------------------------------
module battery_monitor_soc import bms_pkg::*; #(
  parameter int SAMPLES_PER_READING = SamplesPerReading
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // sample channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [AdcW-1:0]   adc_sample_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [MvW-1:0]    battery_mv_o,
  output logic [LevelW-1:0] level_percent_o,
  output logic              battery_low_o,
  // threshold register
  input  logic              cfg_we_i,
  input  logic [MvW-1:0]    cfg_wdata_i
);

  // sum width grows with the group size
  localparam int SumW = $clog2(AdcMax * SAMPLES_PER_READING + 1);

  logic            grp_valid, grp_ready;
  logic [SumW-1:0] grp_sum;
  logic            mv_valid, mv_ready;
  mv_t             mv;
  mv_t             low_thr_q;

  // low-battery threshold; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q <= MvW'(LowThrReset);
    end else if (cfg_we_i) begin
      low_thr_q <= cfg_wdata_i;
    end
  end

  // running sum and group hand-off
  bms_accum #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING),
    .SumW                (SumW)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .adc_sample_i (adc_sample_i),
    .grp_valid_o  (grp_valid),
    .grp_ready_i  (grp_ready),
    .grp_sum_o    (grp_sum)
  );

  // truncated average and fixed-point millivolt conversion
  bms_convert #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING),
    .SumW                (SumW)
  ) u_convert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (grp_valid),
    .grp_ready_o (grp_ready),
    .grp_sum_i   (grp_sum),
    .mv_valid_o  (mv_valid),
    .mv_ready_i  (mv_ready),
    .mv_o        (mv)
  );

  // sigmoid level lookup, low flag and result register
  bms_level u_level (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mv_valid_i      (mv_valid),
    .mv_ready_o      (mv_ready),
    .mv_i            (mv),
    .low_thr_i       (low_thr_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .battery_mv_o    (battery_mv_o),
    .level_percent_o (level_percent_o),
    .battery_low_o   (battery_low_o)
  );

  a_level_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_percent_o <= LevelW'(LevelMax))
    else $error("level above full scale");

  a_full_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && battery_mv_o >= MvW'(MvFull) |-> level_percent_o == LevelW'(LevelMax))
    else $error("full battery not reported as full");

  a_empty_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && battery_mv_o <= MvW'(MvEmpty) |-> level_percent_o == '0)
    else $error("empty battery not reported as empty");

  a_mv_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> battery_mv_o >= MvW'(MvOffset))
    else $error("millivolts below conversion offset");

endmodule
